// ----- src/lfsr_noise_sound_channel_unit_assert.svh -----
// ----------------------------------------------------------------------------
// lfsr_noise_sound_channel_unit_assert.svh
// Assertion macros used by the noise channel checker.
// ----------------------------------------------------------------------------
`ifndef LFSR_NOISE_SOUND_CHANNEL_UNIT_ASSERT_SVH
`define LFSR_NOISE_SOUND_CHANNEL_UNIT_ASSERT_SVH

// same-cycle implication
`define LNSC_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LNSC_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error(msg);

// delayed implication
`define LNSC_ASSERT_TWO(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> ##2 (cons)) \
        else $error(msg);

`endif

// ----- src/lnsc_pkg.sv -----
// ----------------------------------------------------------------------------
// lnsc_pkg
// Types, item codes and register constants of the noise channel.
// ----------------------------------------------------------------------------
package lnsc_pkg;

    // item kinds
    localparam logic [2:0] KIND_WRITE    = 3'd0;
    localparam logic [2:0] KIND_READ     = 3'd1;
    localparam logic [2:0] KIND_TICK     = 3'd2;
    localparam logic [2:0] KIND_LENGTH   = 3'd3;
    localparam logic [2:0] KIND_ENVELOPE = 3'd4;
    localparam logic [2:0] KIND_POWEROFF = 3'd5;

    // register indexes
    localparam logic [2:0] REG_SWEEP = 3'd0;
    localparam logic [2:0] REG_LEN   = 3'd1;
    localparam logic [2:0] REG_ENV   = 3'd2;
    localparam logic [2:0] REG_FREQ  = 3'd3;
    localparam logic [2:0] REG_CTRL  = 3'd4;

    localparam logic [14:0] LFSR_ALL_ONES = 15'h7FFF;
    localparam logic [6:0]  LENGTH_FULL   = 7'd64;
    localparam logic [3:0]  VOLUME_MAX    = 4'hF;
    localparam logic [3:0]  SHIFT_STOP    = 4'd14;
    localparam logic [7:0]  BUS_FLOAT     = 8'hFF;

    typedef struct packed {
        logic [2:0] kind;
        logic [2:0] reg_index;
        logic [7:0] write_data;
    } lnsc_cmd_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [3:0] sample_out;
        logic       channel_on;
    } lnsc_res_t;

    // unused register bits read back as ones
    function automatic logic [7:0] open_bus(input logic [2:0] idx);
        logic [7:0] mask;
        unique case (idx)
            REG_SWEEP: mask = 8'hFF;
            REG_LEN:   mask = 8'hFF;
            REG_ENV:   mask = 8'h00;
            REG_FREQ:  mask = 8'h00;
            REG_CTRL:  mask = 8'hBF;
            default:   mask = BUS_FLOAT;
        endcase
        return mask;
    endfunction

endpackage

// ----- src/lnsc_channels.sv -----
// ----------------------------------------------------------------------------
// lnsc_channels
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface lnsc_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [2:0] reg_index;
    logic [7:0] write_data;

    modport source (output valid, output kind, output reg_index, output write_data,
                    input ready);
    modport sink   (input valid, input kind, input reg_index, input write_data,
                    output ready);
endinterface

interface lnsc_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic [3:0] sample_out;
    logic       channel_on;

    modport source (output valid, output read_data, output sample_out,
                    output channel_on, input ready);
    modport sink   (input valid, input read_data, input sample_out,
                    input channel_on, output ready);
endinterface

// ----- src/lnsc_in_stage.sv -----
// ----------------------------------------------------------------------------
// lnsc_in_stage
// Input register: captures one command item and holds it until it is used.
// ----------------------------------------------------------------------------
module lnsc_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    lnsc_cmd_if.sink          cmd,
    input  logic              advance,
    output lnsc_pkg::lnsc_cmd_t item,
    output logic              item_valid
);

    logic                valid_reg;
    logic                valid_next;
    lnsc_pkg::lnsc_cmd_t item_reg;
    logic                take;

    assign cmd.ready  = !valid_reg || advance;
    assign take       = cmd.valid && cmd.ready;
    assign valid_next = take ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.kind       <= cmd.kind;
            item_reg.reg_index  <= cmd.reg_index;
            item_reg.write_data <= cmd.write_data;
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

// ----- src/lnsc_core.sv -----
// ----------------------------------------------------------------------------
// lnsc_core
// Channel state and its combinational next-state update for one item.
// ----------------------------------------------------------------------------
module lnsc_core (
    input  logic              clk,
    input  logic              rst_n,
    input  lnsc_pkg::lnsc_cmd_t item,
    input  logic              advance,
    output lnsc_pkg::lnsc_res_t result
);

    logic [14:0] lfsr_reg,      lfsr_next;
    logic [19:0] timer_reg,     timer_next;
    logic [3:0]  shift_reg,     shift_next;
    logic [2:0]  divisor_reg,   divisor_next;
    logic        short_reg,     short_next;
    logic [6:0]  length_reg,    length_next;
    logic        len_on_reg,    len_on_next;
    logic        enabled_reg,   enabled_next;
    logic [3:0]  volume_reg,    volume_next;
    logic [3:0]  start_vol_reg, start_vol_next;
    logic        rising_reg,    rising_next;
    logic [2:0]  env_per_reg,   env_per_next;
    logic [2:0]  env_cnt_reg,   env_cnt_next;
    logic [3:0]  level_reg,     level_next;

    logic [6:0]  base;
    logic [19:0] period;
    logic [14:0] lfsr_step;
    logic        feedback;
    logic [7:0]  rd_value;
    logic [7:0]  rd_data;
    logic [7:0]  wd;

    assign wd = item.write_data;

    // period truncates to the timer width at large shifts
    assign base   = (divisor_reg == 3'd0) ? 7'd8 : {divisor_reg, 4'b0000};
    assign period = {13'd0, base} << shift_reg;

    assign feedback  = lfsr_reg[0] ^ lfsr_reg[1];
    always_comb
    begin
        lfsr_step = {feedback, lfsr_reg[14:1]};
        if (short_reg)
        begin
            lfsr_step[6] = feedback;
        end
    end

    always_comb
    begin
        unique case (item.reg_index)
            lnsc_pkg::REG_ENV:  rd_value = {start_vol_reg, rising_reg, env_per_reg};
            lnsc_pkg::REG_FREQ: rd_value = {shift_reg, short_reg, divisor_reg};
            lnsc_pkg::REG_CTRL: rd_value = {1'b0, len_on_reg, 6'd0};
            default:            rd_value = 8'h00;
        endcase
        rd_data = rd_value | lnsc_pkg::open_bus(item.reg_index);
    end

    always_comb
    begin
        lfsr_next      = lfsr_reg;
        timer_next     = timer_reg;
        shift_next     = shift_reg;
        divisor_next   = divisor_reg;
        short_next     = short_reg;
        length_next    = length_reg;
        len_on_next    = len_on_reg;
        enabled_next   = enabled_reg;
        volume_next    = volume_reg;
        start_vol_next = start_vol_reg;
        rising_next    = rising_reg;
        env_per_next   = env_per_reg;
        env_cnt_next   = env_cnt_reg;
        level_next     = level_reg;

        unique case (item.kind)
            lnsc_pkg::KIND_WRITE:
            begin
                unique case (item.reg_index)
                    lnsc_pkg::REG_LEN:
                    begin
                        length_next = lnsc_pkg::LENGTH_FULL - {1'b0, wd[5:0]};
                    end
                    lnsc_pkg::REG_ENV:
                    begin
                        env_per_next   = wd[2:0];
                        rising_next    = wd[3];
                        start_vol_next = wd[7:4];
                        if (wd[7:3] == 5'd0)
                        begin
                            enabled_next = 1'b0;
                        end
                    end
                    lnsc_pkg::REG_FREQ:
                    begin
                        shift_next   = wd[7:4];
                        short_next   = wd[3];
                        divisor_next = wd[2:0];
                    end
                    lnsc_pkg::REG_CTRL:
                    begin
                        if (wd[7])
                        begin
                            enabled_next = rising_reg || (start_vol_reg != 4'd0);
                            timer_next   = period;
                            lfsr_next    = lnsc_pkg::LFSR_ALL_ONES;
                            if (length_reg == 7'd0)
                            begin
                                length_next = lnsc_pkg::LENGTH_FULL;
                            end
                            env_cnt_next = env_per_reg;
                            volume_next  = start_vol_reg;
                        end
                        len_on_next = wd[6];
                    end
                    default:
                    begin
                    end
                endcase
            end
            lnsc_pkg::KIND_TICK:
            begin
                if (shift_reg < lnsc_pkg::SHIFT_STOP)
                begin
                    level_next = (enabled_reg && !lfsr_reg[0]) ? volume_reg : 4'd0;
                    if (timer_reg == 20'd0)
                    begin
                        timer_next = period;
                    end
                    else if (timer_reg == 20'd1)
                    begin
                        timer_next = period;
                        lfsr_next  = lfsr_step;
                    end
                    else
                    begin
                        timer_next = timer_reg - 20'd1;
                    end
                end
            end
            lnsc_pkg::KIND_LENGTH:
            begin
                if (len_on_reg && (length_reg != 7'd0))
                begin
                    length_next = length_reg - 7'd1;
                    if (length_reg == 7'd1)
                    begin
                        enabled_next = 1'b0;
                    end
                end
            end
            lnsc_pkg::KIND_ENVELOPE:
            begin
                if (env_cnt_reg != 3'd0)
                begin
                    env_cnt_next = env_cnt_reg - 3'd1;
                    if (env_cnt_reg == 3'd1)
                    begin
                        if (rising_reg && (volume_reg < lnsc_pkg::VOLUME_MAX))
                        begin
                            volume_next = volume_reg + 4'd1;
                        end
                        else if (!rising_reg && (volume_reg != 4'd0))
                        begin
                            volume_next = volume_reg - 4'd1;
                        end
                        env_cnt_next = env_per_reg;
                    end
                end
            end
            lnsc_pkg::KIND_POWEROFF:
            begin
                // length counter survives power-off
                lfsr_next      = 15'd0;
                timer_next     = 20'd0;
                shift_next     = 4'd0;
                divisor_next   = 3'd0;
                short_next     = 1'b0;
                len_on_next    = 1'b0;
                enabled_next   = 1'b0;
                volume_next    = 4'd0;
                start_vol_next = 4'd0;
                rising_next    = 1'b0;
                env_per_next   = 3'd0;
                env_cnt_next   = 3'd0;
                level_next     = 4'd0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_reg      <= '0;
            timer_reg     <= '0;
            shift_reg     <= '0;
            divisor_reg   <= '0;
            short_reg     <= 1'b0;
            length_reg    <= '0;
            len_on_reg    <= 1'b0;
            enabled_reg   <= 1'b0;
            volume_reg    <= '0;
            start_vol_reg <= '0;
            rising_reg    <= 1'b0;
            env_per_reg   <= '0;
            env_cnt_reg   <= '0;
            level_reg     <= '0;
        end
        else if (advance)
        begin
            lfsr_reg      <= lfsr_next;
            timer_reg     <= timer_next;
            shift_reg     <= shift_next;
            divisor_reg   <= divisor_next;
            short_reg     <= short_next;
            length_reg    <= length_next;
            len_on_reg    <= len_on_next;
            enabled_reg   <= enabled_next;
            volume_reg    <= volume_next;
            start_vol_reg <= start_vol_next;
            rising_reg    <= rising_next;
            env_per_reg   <= env_per_next;
            env_cnt_reg   <= env_cnt_next;
            level_reg     <= level_next;
        end
    end

    assign result.read_data  = (item.kind == lnsc_pkg::KIND_READ) ? rd_data : 8'h00;
    assign result.sample_out = level_next;
    assign result.channel_on = enabled_next;

endmodule

// ----- src/lfsr_noise_sound_channel_unit.sv -----
// ----------------------------------------------------------------------------
// lfsr_noise_sound_channel_unit: noise channel, one item per cycle while the result is not stalled, every kind.
// Items pass the input register, then the state update into the result register.
// Reset (async, rst_n low) clears all channel state; length counter holds 0.
// ----------------------------------------------------------------------------
module lfsr_noise_sound_channel_unit (
    input  logic       clk,
    input  logic       rst_n,
    lnsc_cmd_if.sink   cmd,
    lnsc_res_if.source res
);

    lnsc_pkg::lnsc_cmd_t item;
    logic                item_valid;
    logic                advance;
    lnsc_pkg::lnsc_res_t result;
    lnsc_pkg::lnsc_res_t out_reg;
    logic                out_valid_reg;
    logic                out_valid_next;

    // item moves on when the result register is free or being drained
    assign advance = item_valid && (!out_valid_reg || res.ready);

    lnsc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .advance    (advance),
        .item       (item),
        .item_valid (item_valid)
    );

    lnsc_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .advance (advance),
        .result  (result)
    );

    assign out_valid_next = advance ? 1'b1 : (res.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.read_data  = out_reg.read_data;
    assign res.sample_out = out_reg.sample_out;
    assign res.channel_on = out_reg.channel_on;

endmodule

// ----- src/lnsc_checker.sv -----
// ----------------------------------------------------------------------------
// lnsc_checker
// Port-level checks of the noise channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "lfsr_noise_sound_channel_unit_assert.svh"

module lnsc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       cmd_valid,
    input logic       cmd_ready,
    input logic       res_valid,
    input logic       res_ready,
    input logic [7:0] read_data,
    input logic [3:0] sample_out,
    input logic       channel_on
);

    `LNSC_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid,
                      "result dropped while stalled")
    `LNSC_ASSERT_NEXT(a_res_stable, clk, rst_n, res_valid && !res_ready,
                      $stable({read_data, sample_out, channel_on}), "stalled result changed")
    `LNSC_ASSERT_NOW(a_backpressure, clk, rst_n, !cmd_ready, res_valid && !res_ready,
                     "input stalled without output stall")
    `LNSC_ASSERT_TWO(a_latency, clk, rst_n, cmd_valid && cmd_ready && !res_valid, res_valid,
                     "item not delivered in two cycles")

endmodule

bind lfsr_noise_sound_channel_unit lnsc_checker u_lnsc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .read_data  (res.read_data),
    .sample_out (res.sample_out),
    .channel_on (res.channel_on)
);
